@@ src/assert_macros.svh @@
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/mqsd_pkg.sv @@
package mqsd_pkg;

  // Default number of encoder lanes.
  localparam int unsigned EncodersDef = 5;
  // Pin bits carried per item; lanes at or above this read idle pins.
  localparam int unsigned PinBits = 5;
  localparam int unsigned IdxW = 3;
  localparam int unsigned CfgW = 3;
  localparam int unsigned CountW = 8;

  // Phase / candidate codes (A in bit 1, B in bit 0, after inversion).
  localparam logic [1:0] PH_NONE      = 2'b00;
  localparam logic [1:0] PH_CCW_START = 2'b01;
  localparam logic [1:0] PH_CW_START  = 2'b10;

  // Operation codes.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  typedef logic signed [1:0] step_t;
  typedef logic signed [CountW-1:0] count_t;

  localparam step_t STEP_ZERO = 2'sb00;
  localparam step_t STEP_POS  = 2'sb01;
  localparam step_t STEP_NEG  = 2'sb11;

  localparam count_t COUNT_MAX = 8'sh7f;
  localparam count_t COUNT_MIN = 8'sh80;

  // Per-lane control from the front end.
  typedef struct packed {
    logic       sample;
    logic       consume;
    logic [1:0] phase;
  } lane_ctrl_t;

  // Consume request handed to the merge stage.
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } consume_req_t;

endpackage

@@ src/mqsd_lane.sv @@
module mqsd_lane
  import mqsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_ctrl_t ctrl_i,
  output step_t      step_o
);

  logic [1:0] last_q, last_d;
  logic [1:0] cand_q, cand_d;
  count_t     count_q, count_d;

  // Sign of the pending count is the step a consume returns.
  always_comb begin
    if (count_q > 0) begin
      step_o = STEP_POS;
    end else if (count_q < 0) begin
      step_o = STEP_NEG;
    end else begin
      step_o = STEP_ZERO;
    end
  end

  // Phase tracking and detent counting.
  always_comb begin
    last_d  = last_q;
    cand_d  = cand_q;
    count_d = count_q;
    if (ctrl_i.sample && (ctrl_i.phase != last_q)) begin
      last_d = ctrl_i.phase;
      if (cand_q == PH_NONE) begin
        if ((ctrl_i.phase == PH_CCW_START) || (ctrl_i.phase == PH_CW_START)) begin
          cand_d = ctrl_i.phase;
        end
      end else if (ctrl_i.phase == PH_NONE) begin
        if ((cand_q == PH_CW_START) && (last_q == PH_CCW_START)) begin
          if (count_q != COUNT_MAX) count_d = count_q + count_t'(1);
        end else if ((cand_q == PH_CCW_START) && (last_q == PH_CW_START)) begin
          if (count_q != COUNT_MIN) count_d = count_q - count_t'(1);
        end
        cand_d = PH_NONE;
      end
    end else if (ctrl_i.consume) begin
      // Move one step toward zero.
      if (count_q > 0) begin
        count_d = count_q - count_t'(1);
      end else if (count_q < 0) begin
        count_d = count_q + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= PH_NONE;
      cand_q  <= PH_NONE;
      count_q <= '0;
    end else begin
      last_q  <= last_d;
      cand_q  <= cand_d;
      count_q <= count_d;
    end
  end

endmodule

@@ src/mqsd_merge.sv @@
module mqsd_merge
  import mqsd_pkg::*;
#(
  parameter int unsigned ENCODERS = EncodersDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  step_t        lane_step_i [ENCODERS],
  input  consume_req_t req_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output step_t        out_step_o
);

  step_t sel_step;
  logic  out_v_q, out_v_d, skid_v_q, skid_v_d;
  step_t out_q, out_d, skid_q, skid_d;
  logic  pop;

  // Pick the addressed lane; out-of-range index gives zero.
  always_comb begin
    sel_step = STEP_ZERO;
    for (int i = 0; i < ENCODERS; i++) begin
      if (32'(req_i.idx) == i) sel_step = lane_step_i[i];
    end
  end

  // Two-entry result buffer: output register plus skid register.
  assign pop     = out_v_q && out_ready_i;
  assign ready_o = !skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = req_i.valid;
        skid_d   = sel_step;
      end else begin
        out_v_d = req_i.valid;
        out_d   = sel_step;
      end
    end else if (req_i.valid) begin
      skid_v_d = 1'b1;
      skid_d   = sel_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_step_o  = out_q;

endmodule

@@ src/multi_quadrature_step_decoder.sv @@
// Channel   Direction  Transfer when              Payload
// s_axis    in         s_axis_tvalid & tready     tdata: pin_a, pin_b, index; tuser: op
// m_axis    out        m_axis_tvalid & tready     tdata: step
// cfg       in         cfg_valid_i & cfg_ready_o  active_encoders
//
// One item is taken every cycle while s_axis_tready is high; a sample updates the
// active lanes, a consume the indexed lane, in the cycle of the transfer. A consume
// result is registered; a sample gives none. s_axis_tready drops only while two
// results are buffered (a consume came in while m_axis held a stalled result) and
// rises again the cycle after the next m_axis transfer. Reset clears all lane
// state, the result buffer and active_encoders; the config port is always ready.
module multi_quadrature_step_decoder
  import mqsd_pkg::*;
#(
  parameter int unsigned ENCODERS = EncodersDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,  // [4:0] pin_a_levels, [9:5] pin_b_levels,
                                         // [12:10] encoder_index, [15:13] zero
  input  logic            s_axis_tuser,  // [0] operation
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [1:0] step (signed), [7:2] zero
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i     // active_encoders
);

  `include "assert_macros.svh"

  logic [CfgW-1:0]    active_q;
  logic [PinBits-1:0] pin_a, pin_b;
  logic [IdxW-1:0]    idx;
  logic               accept;
  logic               sample_acc;
  lane_ctrl_t         lane_ctrl [ENCODERS];
  step_t              lane_step [ENCODERS];
  consume_req_t       req;
  step_t              out_step;

  assign pin_a      = s_axis_tdata[PinBits-1:0];
  assign pin_b      = s_axis_tdata[2*PinBits-1:PinBits];
  assign idx        = s_axis_tdata[2*PinBits+IdxW-1:2*PinBits];
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign sample_acc = accept && (s_axis_tuser == OP_SAMPLE);

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  // Lanes: each below PinBits decodes its own pin pair; the rest see idle pins.
  for (genvar g = 0; g < ENCODERS; g++) begin : g_lane
    if (g < PinBits) begin : g_pins
      assign lane_ctrl[g].phase = {~pin_a[g], ~pin_b[g]};
    end else begin : g_idle
      assign lane_ctrl[g].phase = PH_NONE;
    end
    assign lane_ctrl[g].sample  = sample_acc && (32'(active_q) > g);
    assign lane_ctrl[g].consume = accept && (s_axis_tuser == OP_CONSUME)
                                  && (32'(idx) == g);

    mqsd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl[g]),
      .step_o (lane_step[g])
    );
  end

  // Merge lane steps into the result stream.
  assign req.valid = accept && (s_axis_tuser == OP_CONSUME);
  assign req.idx   = idx;

  mqsd_merge #(
    .ENCODERS (ENCODERS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lane_step_i (lane_step),
    .req_i       (req),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_step_o  (out_step)
  );

  assign m_axis_tdata = {6'b0, out_step};

  // Checks.
  `ASSERT_CLK(a_stall_has_result, !s_axis_tready |-> m_axis_tvalid, "stall without result")
  `ASSERT_CLK(a_consume_shows, (req.valid && !m_axis_tvalid) |=> m_axis_tvalid, "result missing")
  `ASSERT_CLK(a_sample_silent, (sample_acc && !m_axis_tvalid) |=> !m_axis_tvalid, "extra result")
  `ASSERT_CLK(a_step_legal, m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b10), "illegal step code")

endmodule
